// ===== src/segment_intersection_test_defines.svh =====
// Assertion macros for the segment intersection RTL, used by the top level.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Checked only outside reset.
`define SIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/sit_pkg.sv =====
// Types, widths and helper functions for the segment intersection pipeline.
package sit_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int N_ORIENT = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Operands of o(p,q,r) = (q.y-p.y)*(r.x-q.x) - (q.x-p.x)*(r.y-q.y)
  typedef struct packed {
    diff_t qy_py;
    diff_t rx_qx;
    diff_t qx_px;
    diff_t ry_qy;
  } odiff_t;

  typedef struct packed {
    prod_t lhs;
    prod_t rhs;
  } oprod_t;

  typedef struct packed {
    logic                          valid;
    odiff_t [N_ORIENT-1:0]         od;
    logic   [N_ORIENT-1:0]         box;
  } prep_t;

  typedef struct packed {
    logic                          valid;
    oprod_t [N_ORIENT-1:0]         op;
    logic   [N_ORIENT-1:0]         box;
  } mult_t;

  function automatic odiff_t orient_diffs(point_t p, point_t q, point_t r);
    odiff_t o;
    o.qy_py = diff_t'($signed(q.y)) - diff_t'($signed(p.y));
    o.rx_qx = diff_t'($signed(r.x)) - diff_t'($signed(q.x));
    o.qx_px = diff_t'($signed(q.x)) - diff_t'($signed(p.x));
    o.ry_qy = diff_t'($signed(r.y)) - diff_t'($signed(q.y));
    return o;
  endfunction

  // m inside the bounding box of a-b, edges included
  function automatic logic box_hit(point_t a, point_t m, point_t b);
    logic hx;
    logic hy;
    hx = (($signed(m.x) >= $signed(a.x)) || ($signed(m.x) >= $signed(b.x))) &&
         (($signed(m.x) <= $signed(a.x)) || ($signed(m.x) <= $signed(b.x)));
    hy = (($signed(m.y) >= $signed(a.y)) || ($signed(m.y) >= $signed(b.y))) &&
         (($signed(m.y) <= $signed(a.y)) || ($signed(m.y) <= $signed(b.y)));
    return hx && hy;
  endfunction

endpackage

// ===== src/sit_prep.sv =====
// Stage 1: coordinate differences and bounding-box tests.
module sit_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  sit_pkg::point_t  a0_i,
  input  sit_pkg::point_t  a1_i,
  input  sit_pkg::point_t  b0_i,
  input  sit_pkg::point_t  b1_i,
  output sit_pkg::prep_t   prep_o
);

  sit_pkg::prep_t prep_d, prep_q;

  always_comb begin
    prep_d.valid  = valid_i;
    prep_d.od[0]  = sit_pkg::orient_diffs(a0_i, a1_i, b0_i);
    prep_d.od[1]  = sit_pkg::orient_diffs(a0_i, a1_i, b1_i);
    prep_d.od[2]  = sit_pkg::orient_diffs(b0_i, b1_i, a0_i);
    prep_d.od[3]  = sit_pkg::orient_diffs(b0_i, b1_i, a1_i);
    prep_d.box[0] = sit_pkg::box_hit(a0_i, b0_i, a1_i);
    prep_d.box[1] = sit_pkg::box_hit(a0_i, b1_i, a1_i);
    prep_d.box[2] = sit_pkg::box_hit(b0_i, a0_i, b1_i);
    prep_d.box[3] = sit_pkg::box_hit(b0_i, a1_i, b1_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else if (en_i) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

// ===== src/sit_mult.sv =====
// Stage 2: the two cross-product terms of each orientation.
module sit_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  sit_pkg::prep_t  prep_i,
  output sit_pkg::mult_t  mult_o
);

  sit_pkg::mult_t mult_d, mult_q;

  always_comb begin
    mult_d.valid = prep_i.valid;
    mult_d.box   = prep_i.box;
    for (int k = 0; k < sit_pkg::N_ORIENT; k++) begin
      mult_d.op[k].lhs = sit_pkg::prod_t'($signed(prep_i.od[k].qy_py)) *
                         sit_pkg::prod_t'($signed(prep_i.od[k].rx_qx));
      mult_d.op[k].rhs = sit_pkg::prod_t'($signed(prep_i.od[k].qx_px)) *
                         sit_pkg::prod_t'($signed(prep_i.od[k].ry_qy));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= '0;
    end else if (en_i) begin
      mult_q <= mult_d;
    end
  end

  assign mult_o = mult_q;

endmodule

// ===== src/sit_decide.sv =====
// Stage 3: orientation signs and the final meet decision, into the output register.
module sit_decide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  sit_pkg::mult_t  mult_i,
  output logic            valid_o,
  output logic            meet_o
);

  logic [sit_pkg::N_ORIENT-1:0] pos, neg, zero;
  logic valid_q, meet_q, meet_d;

  always_comb begin
    for (int k = 0; k < sit_pkg::N_ORIENT; k++) begin
      pos[k]  = $signed(mult_i.op[k].lhs) > $signed(mult_i.op[k].rhs);
      neg[k]  = $signed(mult_i.op[k].lhs) < $signed(mult_i.op[k].rhs);
      zero[k] = !pos[k] && !neg[k];
    end
    // strict crossing, or a collinear endpoint touching the other segment
    meet_d = (((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
              ((pos[2] && neg[3]) || (neg[2] && pos[3]))) ||
             (|(zero & mult_i.box));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      meet_q  <= 1'b0;
    end else if (en_i) begin
      valid_q <= mult_i.valid;
      meet_q  <= meet_d;
    end
  end

  assign valid_o = valid_q;
  assign meet_o  = meet_q;

endmodule

// ===== src/segment_intersection_test.sv =====
// Segment intersection test: three-stage pipeline (differences, products, decision).
// An accepted input beat passes the stage 1, stage 2 and output registers in turn to its result beat.
// Throughput: one beat per cycle; the pipeline holds in place while the output is stalled.
// The stall back to the input is the output register being full and stalled.
// Reset (rst_ni low, asynchronous) empties every stage; no state beyond the pipeline.
`include "segment_intersection_test_defines.svh"

module segment_intersection_test (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sit_pkg::coord_t        first_start_x_i,
  input  sit_pkg::coord_t        first_start_y_i,
  input  sit_pkg::coord_t        first_end_x_i,
  input  sit_pkg::coord_t        first_end_y_i,
  input  sit_pkg::coord_t        second_start_x_i,
  input  sit_pkg::coord_t        second_start_y_i,
  input  sit_pkg::coord_t        second_end_x_i,
  input  sit_pkg::coord_t        second_end_y_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   segments_meet_o
);

  logic            en;
  sit_pkg::point_t a0, a1, b0, b1;
  sit_pkg::prep_t  prep;
  sit_pkg::mult_t  mult;

  // whole pipeline advances unless the output beat is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign a0 = '{x: first_start_x_i,  y: first_start_y_i};
  assign a1 = '{x: first_end_x_i,    y: first_end_y_i};
  assign b0 = '{x: second_start_x_i, y: second_start_y_i};
  assign b1 = '{x: second_end_x_i,   y: second_end_y_i};

  sit_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a0_i    (a0),
    .a1_i    (a1),
    .b0_i    (b0),
    .b1_i    (b1),
    .prep_o  (prep)
  );

  sit_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .prep_i  (prep),
    .mult_o  (mult)
  );

  sit_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .mult_i  (mult),
    .valid_o (out_valid_o),
    .meet_o  (segments_meet_o)
  );

  `SIT_ASSERT(a_accept_enters, (in_valid_i && !in_stall_o) |=> prep.valid, "stage 1 beat lost")
  `SIT_ASSERT(a_hold_stage1, !en |=> $stable(prep), "stage 1 moved while stalled")
  `SIT_ASSERT(a_hold_out, !en |=> ($stable(mult) && $stable(out_valid_o)), "stage 3 moved")
  `SIT_ASSERT(a_stage2_to_out, (mult.valid && en) |=> out_valid_o, "stage 2 beat lost")
  // flops settle to empty by the edge after reset is seen
  `SIT_ASSERT_ALWAYS(a_reset_out, !rst_ni |=> !out_valid_o, "output valid after reset")
  `SIT_ASSERT_ALWAYS(a_reset_stages, !rst_ni |=> !(prep.valid || mult.valid), "stage valid after reset")

endmodule
